### src/two_voice_note_sequencer_defines.svh
// assertion macros shared by the sequencer rtl
`ifndef TWO_VOICE_NOTE_SEQUENCER_DEFINES_SVH
`define TWO_VOICE_NOTE_SEQUENCER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TVNS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TVNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tvns_pkg.sv
`default_nettype none

package tvns_pkg;

  // field widths
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned FUNC_W  = 2;

  // base plus index plus one always fits here
  localparam int unsigned SUM_W = 8;

  // configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_W  = 3;

  // parameter defaults
  localparam int unsigned NOTE_SLOTS_DEF   = 64;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd8192;
  localparam logic [TICKS_W-1:0] TICK_MAX   = 24'hFFFFFF;

  // sine polynomial coefficients, q14
  localparam logic [31:0] SIN_A = 32'd25718;
  localparam logic [31:0] SIN_B = 32'd10477;
  localparam logic [31:0] SIN_C = 32'd1142;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [REG_W-1:0] {
    REG_BASE_ONE   = 3'd0,
    REG_LENGTH_ONE = 3'd1,
    REG_BASE_TWO   = 3'd2,
    REG_LENGTH_TWO = 3'd3,
    REG_GAIN_ONE   = 3'd4,
    REG_GAIN_TWO   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [TICKS_W-1:0] ticks;
  } note_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    note_t             note;
  } note_wr_t;

  typedef struct packed {
    logic start;
    logic tick;
    logic playing;
  } ctrl_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  // q14 sine of a 16 bit turn fraction, quadrant in the top two bits
  function automatic sine_t sine_of_turn(input logic [15:0] turn);
    logic [31:0] z;
    logic [31:0] z2;
    logic [31:0] t;
    logic [31:0] t2;
    sine_t       s;
    z = {18'd0, turn[13:0]};
    if (turn[14]) begin
      z = 32'd16384 - z;
    end
    z2    = (z * z) >> 14;
    t     = SIN_B - ((z2 * SIN_C) >> 14);
    t2    = SIN_A - ((z2 * t) >> 14);
    s.mag = MAG_W'((z * t2) >> 14);
    s.neg = turn[15];
    return s;
  endfunction

endpackage

`default_nettype wire

### src/tvns_note_store.sv
`default_nettype none

// note store, one write port, two registered read ports, write-first
module tvns_note_store #(
  parameter int unsigned NoteSlots = tvns_pkg::NOTE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  tvns_pkg::note_wr_t          wr_i,
  input  logic [tvns_pkg::SUM_W-1:0]  cur_sum_i,
  input  logic [tvns_pkg::SUM_W-1:0]  nxt_sum_i,
  output tvns_pkg::note_t             cur_o,
  output tvns_pkg::note_t             nxt_o
);

  localparam int unsigned AddrW = $clog2(NoteSlots);
  localparam int unsigned WrapN = 2 ** tvns_pkg::SUM_W;

  tvns_pkg::note_t  mem [NoteSlots];
  logic [AddrW-1:0] wrap [WrapN];

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] cur_a;
  logic [AddrW-1:0] nxt_a;
  tvns_pkg::note_t  cur_q;
  tvns_pkg::note_t  nxt_q;

  // slot sums wrap around the store
  for (genvar g = 0; g < WrapN; g++) begin : g_wrap
    localparam int unsigned Slot = g % NoteSlots;
    assign wrap[g] = AddrW'(Slot);
  end

  assign we    = wr_i.en && (32'(wr_i.slot) < NoteSlots);
  assign waddr = AddrW'(wr_i.slot);
  assign cur_a = wrap[cur_sum_i];
  assign nxt_a = wrap[nxt_sum_i];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wr_i.note;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= (we && (waddr == cur_a)) ? wr_i.note : mem[cur_a];
    nxt_q <= (we && (waddr == nxt_a)) ? wr_i.note : mem[nxt_a];
  end

  assign cur_o = cur_q;
  assign nxt_o = nxt_q;

endmodule

`default_nettype wire

### src/tvns_sine_rom.sv
`default_nettype none

// sine table with registered read, addressed by the top bits of a phase
module tvns_sine_rom #(
  parameter int unsigned SineEntries = tvns_pkg::SINE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic [tvns_pkg::STEP_W-1:0]  phase_i,
  output tvns_pkg::sine_t              sine_o
);

  localparam int unsigned EntW = $clog2(SineEntries);
  localparam int unsigned MulW = $clog2(SineEntries + 1);
  localparam int unsigned ProdW = tvns_pkg::STEP_W + MulW;

  tvns_pkg::sine_t  rom [SineEntries];
  logic [ProdW-1:0] prod;
  logic [EntW-1:0]  entry;
  tvns_pkg::sine_t  sine_q;

  for (genvar g = 0; g < SineEntries; g++) begin : g_rom
    localparam int unsigned Turn = (g * 65536) / SineEntries;
    assign rom[g] = tvns_pkg::sine_of_turn(16'(Turn));
  end

  // entry = phase * entries / 2^32
  assign prod  = ProdW'(phase_i) * ProdW'(SineEntries);
  assign entry = prod[tvns_pkg::STEP_W +: EntW];

  always_ff @(posedge clk_i) begin
    sine_q <= rom[entry];
  end

  assign sine_o = sine_q;

endmodule

`default_nettype wire

### src/tvns_voice.sv
`default_nettype none

// one voice: note position, elapsed ticks, phase and drive
module tvns_voice #(
  parameter int unsigned NoteSlots   = tvns_pkg::NOTE_SLOTS_DEF,
  parameter int unsigned SineEntries = tvns_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tvns_pkg::ctrl_t                     ctrl_i,
  input  logic                                play_next_i,
  input  tvns_pkg::note_wr_t                  wr_i,
  input  logic        [tvns_pkg::SLOT_W-1:0]  base_i,
  input  logic        [tvns_pkg::INDEX_W-1:0] length_i,
  input  logic        [tvns_pkg::GAIN_W-1:0]  gain_i,
  output logic                                busy_o,
  output logic signed [tvns_pkg::DRIVE_W-1:0] drive_o
);

  logic [tvns_pkg::INDEX_W-1:0] index_q, index_d, index_n;
  logic [tvns_pkg::TICKS_W-1:0] elapsed_q, elapsed_d;
  logic [tvns_pkg::STEP_W-1:0]  phase_q, phase_d;

  tvns_pkg::note_t cur_note;
  tvns_pkg::note_t nxt_note;
  tvns_pkg::note_t sel_note;
  tvns_pkg::sine_t sine;

  logic                        adv;
  logic                        run;
  logic [tvns_pkg::SUM_W-1:0]  cur_sum;
  logic [tvns_pkg::SUM_W-1:0]  nxt_sum;
  logic [31:0]                 prod;
  logic [32:0]                 rnd;
  logic [18:0]                 mag;
  logic [tvns_pkg::DRIVE_W-1:0] pos;

  // note change when the current note has run its duration
  assign adv     = ctrl_i.playing && (index_q < length_i) && (elapsed_q >= cur_note.ticks);
  assign index_n = index_q + tvns_pkg::INDEX_W'(adv);
  assign busy_o  = ctrl_i.playing && (index_n < length_i);
  assign run     = play_next_i && busy_o;
  assign sel_note = adv ? nxt_note : cur_note;

  always_comb begin
    index_d   = index_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    if (ctrl_i.start) begin
      index_d   = '0;
      elapsed_d = '0;
      phase_d   = '0;
    end else if (ctrl_i.tick) begin
      index_d   = index_n;
      elapsed_d = adv ? '0 : elapsed_q;
      phase_d   = adv ? '0 : phase_q;
      if (run) begin
        if (elapsed_d != tvns_pkg::TICK_MAX) begin
          elapsed_d = elapsed_d + tvns_pkg::TICKS_W'(1);
        end
        phase_d = phase_d + sel_note.step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q   <= '0;
      elapsed_q <= '0;
      phase_q   <= '0;
    end else begin
      index_q   <= index_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
    end
  end

  // stores are read at the next position so the notes are ready for the next item
  assign cur_sum = tvns_pkg::SUM_W'(base_i) + tvns_pkg::SUM_W'(index_d);
  assign nxt_sum = cur_sum + tvns_pkg::SUM_W'(1);

  tvns_note_store #(
    .NoteSlots (NoteSlots)
  ) u_note_store (
    .clk_i     (clk_i),
    .wr_i      (wr_i),
    .cur_sum_i (cur_sum),
    .nxt_sum_i (nxt_sum),
    .cur_o     (cur_note),
    .nxt_o     (nxt_note)
  );

  tvns_sine_rom #(
    .SineEntries (SineEntries)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .phase_i (phase_d),
    .sine_o  (sine)
  );

  // gain scaling with rounding and saturation
  assign prod = 32'(gain_i) * 32'(sine.mag);
  assign rnd  = 33'(prod) + 33'd8192;
  assign mag  = rnd[32:14];
  assign pos  = (mag > 19'd32767) ? 16'sd32767 : mag[tvns_pkg::DRIVE_W-1:0];

  always_comb begin
    drive_o = '0;
    if (run && !adv && (sel_note.step != '0)) begin
      if (!sine.neg) begin
        drive_o = pos;
      end else if (mag > 19'd32768) begin
        drive_o = -16'sd32768;
      end else begin
        drive_o = -(mag[tvns_pkg::DRIVE_W-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

### src/two_voice_note_sequencer.sv
// two voice note sequencer
//
// input channel (in_valid_i / in_stall_o) carries one item per handshake:
// a note load into the note store, a start, or a one microsecond tick.
// only a tick makes a result item on the output channel
// (out_valid_o / out_stall_i) with both drive values, the busy flags and
// the finished flag.
// an accepted item sits in the input register and is worked on there in a
// single pass; a tick's result is then captured in the result register,
// which shows it on the output channel.
// throughput is one item per clock unless a tick waits on a held result;
// the single pass through the voice update allows it; note store and sine
// table are read ahead so their registered data is ready for the next item.
// when the receiver stalls a waiting result holds, loads and starts still
// go through, and a further tick waits in the input register.
// reset clears the voice positions, the input and result valid bits and
// the configuration registers; the note store keeps whatever it holds
// and must be loaded before use, no clearing pass is made.
// registers sit on an apb port at 4 byte steps and are read back live.

`default_nettype none

`include "two_voice_note_sequencer_defines.svh"

module two_voice_note_sequencer #(
  parameter int unsigned NoteSlots   = tvns_pkg::NOTE_SLOTS_DEF,
  parameter int unsigned SineEntries = tvns_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [tvns_pkg::FUNC_W-1:0]   func_i,
  input  logic        [tvns_pkg::SLOT_W-1:0]   note_slot_i,
  input  logic        [tvns_pkg::STEP_W-1:0]   note_step_i,
  input  logic        [tvns_pkg::TICKS_W-1:0]  note_ticks_i,
  // result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tvns_pkg::DRIVE_W-1:0]  drive_one_o,
  output logic signed [tvns_pkg::DRIVE_W-1:0]  drive_two_o,
  output logic                                 voice_one_busy_o,
  output logic                                 voice_two_busy_o,
  output logic                                 finished_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [tvns_pkg::APB_AW-1:0]   paddr,
  input  logic        [tvns_pkg::APB_DW-1:0]   pwdata,
  output logic        [tvns_pkg::APB_DW-1:0]   prdata,
  output logic                                 pready
);

  // input register
  logic                           in_vld_q;
  logic [tvns_pkg::FUNC_W-1:0]    func_q;
  logic [tvns_pkg::SLOT_W-1:0]    slot_q;
  logic [tvns_pkg::STEP_W-1:0]    step_q;
  logic [tvns_pkg::TICKS_W-1:0]   ticks_q;
  logic                           in_take;
  logic                           proceed;
  logic                           fire;

  // control
  tvns_pkg::ctrl_t                ctrl;
  tvns_pkg::note_wr_t             note_wr;
  logic                           playing_q, playing_d;
  logic                           play_next;
  logic                           busy_one, busy_two;
  logic signed [tvns_pkg::DRIVE_W-1:0] drive_one, drive_two;

  // result register
  logic                           out_vld_q, out_vld_d;
  logic signed [tvns_pkg::DRIVE_W-1:0] drive_one_q, drive_two_q;
  logic                           busy_one_q, busy_two_q, fin_q;

  // configuration registers
  logic [tvns_pkg::SLOT_W-1:0]    base_one_q, base_one_d;
  logic [tvns_pkg::SLOT_W-1:0]    base_two_q, base_two_d;
  logic [tvns_pkg::INDEX_W-1:0]   length_one_q, length_one_d;
  logic [tvns_pkg::INDEX_W-1:0]   length_two_q, length_two_d;
  logic [tvns_pkg::GAIN_W-1:0]    gain_one_q, gain_one_d;
  logic [tvns_pkg::GAIN_W-1:0]    gain_two_q, gain_two_d;
  logic                           cfg_wr;
  tvns_pkg::reg_e                 cfg_idx;

  // ---------------------------------------------------------------
  // input side: a tick only goes when the result register can take it
  // ---------------------------------------------------------------
  assign proceed = (tvns_pkg::func_e'(func_q) != tvns_pkg::FUNC_TICK) ||
                   !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && proceed;
  assign in_stall_o = in_vld_q && !proceed;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (proceed) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q  <= func_i;
      slot_q  <= note_slot_i;
      step_q  <= note_step_i;
      ticks_q <= note_ticks_i;
    end
  end

  // item decode, the unused code does nothing
  always_comb begin
    ctrl.start         = 1'b0;
    ctrl.tick          = 1'b0;
    ctrl.playing       = playing_q;
    note_wr.en         = 1'b0;
    note_wr.slot       = slot_q;
    note_wr.note.step  = step_q;
    note_wr.note.ticks = ticks_q;
    if (fire) begin
      unique case (tvns_pkg::func_e'(func_q))
        tvns_pkg::FUNC_LOAD:  note_wr.en = 1'b1;
        tvns_pkg::FUNC_START: ctrl.start = 1'b1;
        tvns_pkg::FUNC_TICK:  ctrl.tick  = 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // voices
  // ---------------------------------------------------------------
  assign play_next = busy_one || busy_two;

  tvns_voice #(
    .NoteSlots   (NoteSlots),
    .SineEntries (SineEntries)
  ) u_voice_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .play_next_i (play_next),
    .wr_i        (note_wr),
    .base_i      (base_one_d),
    .length_i    (length_one_q),
    .gain_i      (gain_one_q),
    .busy_o      (busy_one),
    .drive_o     (drive_one)
  );

  tvns_voice #(
    .NoteSlots   (NoteSlots),
    .SineEntries (SineEntries)
  ) u_voice_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .play_next_i (play_next),
    .wr_i        (note_wr),
    .base_i      (base_two_d),
    .length_i    (length_two_q),
    .gain_i      (gain_two_q),
    .busy_o      (busy_two),
    .drive_o     (drive_two)
  );

  // playback runs from a start until no voice is left busy
  always_comb begin
    playing_d = playing_q;
    if (ctrl.start) begin
      playing_d = 1'b1;
    end else if (ctrl.tick) begin
      playing_d = play_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
    end else begin
      playing_q <= playing_d;
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  assign out_vld_d = ctrl.tick || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.tick) begin
      drive_one_q <= drive_one;
      drive_two_q <= drive_two;
      busy_one_q  <= busy_one;
      busy_two_q  <= busy_two;
      fin_q       <= !play_next;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign drive_one_o      = drive_one_q;
  assign drive_two_o      = drive_two_q;
  assign voice_one_busy_o = busy_one_q;
  assign voice_two_busy_o = busy_two_q;
  assign finished_o       = fin_q;

  // ---------------------------------------------------------------
  // configuration registers, next values also steer the note reads
  // ---------------------------------------------------------------
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tvns_pkg::reg_e'(paddr[tvns_pkg::APB_AW-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    base_one_d   = base_one_q;
    base_two_d   = base_two_q;
    length_one_d = length_one_q;
    length_two_d = length_two_q;
    gain_one_d   = gain_one_q;
    gain_two_d   = gain_two_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        tvns_pkg::REG_BASE_ONE:   base_one_d   = pwdata[tvns_pkg::SLOT_W-1:0];
        tvns_pkg::REG_LENGTH_ONE: length_one_d = pwdata[tvns_pkg::INDEX_W-1:0];
        tvns_pkg::REG_BASE_TWO:   base_two_d   = pwdata[tvns_pkg::SLOT_W-1:0];
        tvns_pkg::REG_LENGTH_TWO: length_two_d = pwdata[tvns_pkg::INDEX_W-1:0];
        tvns_pkg::REG_GAIN_ONE:   gain_one_d   = pwdata[tvns_pkg::GAIN_W-1:0];
        tvns_pkg::REG_GAIN_TWO:   gain_two_d   = pwdata[tvns_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_one_q   <= '0;
      base_two_q   <= '0;
      length_one_q <= '0;
      length_two_q <= '0;
      gain_one_q   <= tvns_pkg::GAIN_RESET;
      gain_two_q   <= tvns_pkg::GAIN_RESET;
    end else begin
      base_one_q   <= base_one_d;
      base_two_q   <= base_two_d;
      length_one_q <= length_one_d;
      length_two_q <= length_two_d;
      gain_one_q   <= gain_one_d;
      gain_two_q   <= gain_two_d;
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      tvns_pkg::REG_BASE_ONE:   prdata = tvns_pkg::APB_DW'(base_one_q);
      tvns_pkg::REG_LENGTH_ONE: prdata = tvns_pkg::APB_DW'(length_one_q);
      tvns_pkg::REG_BASE_TWO:   prdata = tvns_pkg::APB_DW'(base_two_q);
      tvns_pkg::REG_LENGTH_TWO: prdata = tvns_pkg::APB_DW'(length_two_q);
      tvns_pkg::REG_GAIN_ONE:   prdata = tvns_pkg::APB_DW'(gain_one_q);
      tvns_pkg::REG_GAIN_TWO:   prdata = tvns_pkg::APB_DW'(gain_two_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  `TVNS_ASSERT_SAME(a_tick_has_room, clk_i, rst_ni, ctrl.tick, !(out_vld_q && out_stall_i), "tick over a held result")
  `TVNS_ASSERT_NEXT(a_start_plays, clk_i, rst_ni, ctrl.start, playing_q, "start did not begin playback")
  `TVNS_ASSERT_NEXT(a_held_item_kept, clk_i, rst_ni, in_vld_q && in_stall_o, in_vld_q && $stable(func_q), "held item lost")
  `TVNS_ASSERT_SAME(a_finish_idle, clk_i, rst_ni, out_vld_q, !(fin_q && (busy_one_q || busy_two_q)), "finished with a busy voice")
  `TVNS_ASSERT_SAME(a_drive_busy, clk_i, rst_ni, out_vld_q, (drive_one_q == '0 || busy_one_q) && (drive_two_q == '0 || busy_two_q), "drive from an idle voice")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
  import tvns_pkg::*;

  // sizes and constants of the prediction
  localparam int unsigned SLOT_COUNT = 64;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TICKS_W-1:0] TICKS_FULL = 24'hFFFFFF;
  localparam int unsigned POLY_A = 25718;
  localparam int unsigned POLY_B = 10477;
  localparam int unsigned POLY_C = 1142;

  // run shape
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 95;
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned RUN_LIMIT = 10_000_000;

  // one item waiting to be sent, drain holds it back until all results are in
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  slot;
    logic [STEP_W-1:0]  step;
    logic [TICKS_W-1:0] ticks;
    bit                 drain;
  } seq_cmd_t;

  // one expected result item
  typedef struct {
    logic signed [DRIVE_W-1:0] drive_one;
    logic signed [DRIVE_W-1:0] drive_two;
    logic                      busy_one;
    logic                      busy_two;
    logic                      finished;
  } tone_frame_t;

  // clock, reset and block ports
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func  = '0;
  logic [SLOT_W-1:0]  in_slot  = '0;
  logic [STEP_W-1:0]  in_step  = '0;
  logic [TICKS_W-1:0] in_ticks = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive_one;
  logic signed [DRIVE_W-1:0] drive_two;
  logic                      busy_one;
  logic                      busy_two;
  logic                      finished;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  two_voice_note_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (in_func),
    .note_slot_i      (in_slot),
    .note_step_i      (in_step),
    .note_ticks_i     (in_ticks),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .drive_one_o      (drive_one),
    .drive_two_o      (drive_two),
    .voice_one_busy_o (busy_one),
    .voice_two_busy_o (busy_two),
    .finished_o       (finished),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // shadow copy of the sequencer: note store, registers, voice positions
  note_t              score [SLOT_COUNT];
  logic [SLOT_W-1:0]  cfg_base [2] = '{6'd0, 6'd0};
  logic [INDEX_W-1:0] cfg_len  [2] = '{7'd0, 7'd0};
  logic [GAIN_W-1:0]  cfg_gain [2] = '{16'd8192, 16'd8192};
  logic [INDEX_W-1:0] voice_pos     [2] = '{7'd0, 7'd0};
  logic [TICKS_W-1:0] voice_elapsed [2] = '{24'd0, 24'd0};
  logic [STEP_W-1:0]  voice_phase   [2] = '{32'd0, 32'd0};
  bit                 running = 1'b0;

  seq_cmd_t    cmds_waiting [$];
  tone_frame_t frames_due [$];

  int gap_left       = 0;
  int stall_left     = 0;
  int run_left       = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;
  int mismatch_total = 0;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // q14 sine: top ten phase bits pick the entry, polynomial per quadrant
  function automatic int sine_q14(logic [STEP_W-1:0] ph);
    logic [9:0]  entry;
    int unsigned z;
    int unsigned z2;
    int unsigned t;
    int unsigned t2;
    int unsigned s;
    entry = ph[31:22];
    z = {entry[7:0], 6'd0};
    // odd quadrants run the curve backward
    if (entry[8]) begin
      z = 16384 - z;
    end
    z2 = (z * z) >> 14;
    t  = POLY_B - ((z2 * POLY_C) >> 14);
    t2 = POLY_A - ((z2 * t) >> 14);
    s  = (z * t2) >> 14;
    return entry[9] ? -int'(s) : int'(s);
  endfunction

  // gain times sine, rounded on the magnitude, then clipped to 16 bits
  function automatic logic signed [DRIVE_W-1:0] scaled_drive(logic [GAIN_W-1:0] gain, int sn);
    longint mag;
    longint v;
    mag = (sn < 0) ? -longint'(sn) : longint'(sn);
    v = (longint'(gain) * mag + 8192) >>> 14;
    if (sn < 0) begin
      v = -v;
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return DRIVE_W'(v);
  endfunction

  // applies one accepted item to the shadow state, a tick queues its result
  function automatic void play_item(seq_cmd_t c);
    tone_frame_t               fr;
    logic [SLOT_W-1:0]         a;
    bit                        on [2];
    logic signed [DRIVE_W-1:0] d [2];
    int                        v;
    on = '{1'b0, 1'b0};
    d  = '{16'sd0, 16'sd0};
    if (c.func == FUNC_LOAD) begin
      score[c.slot].step  = c.step;
      score[c.slot].ticks = c.ticks;
    end else if (c.func == FUNC_START) begin
      for (v = 0; v < 2; v++) begin
        voice_pos[v]     = '0;
        voice_elapsed[v] = '0;
        voice_phase[v]   = '0;
      end
      running = 1'b1;
    end else if (c.func == FUNC_TICK) begin
      // note change first, store address wraps at the slot count
      if (running) begin
        for (v = 0; v < 2; v++) begin
          a = SLOT_W'(cfg_base[v] + voice_pos[v]);
          if (voice_pos[v] < cfg_len[v] && voice_elapsed[v] >= score[a].ticks) begin
            voice_pos[v]     = voice_pos[v] + 1'b1;
            voice_elapsed[v] = '0;
            voice_phase[v]   = '0;
          end
          on[v] = voice_pos[v] < cfg_len[v];
        end
        running = on[0] || on[1];
      end
      // a rest keeps the drive at zero but time still runs
      if (running) begin
        for (v = 0; v < 2; v++) begin
          if (on[v]) begin
            a = SLOT_W'(cfg_base[v] + voice_pos[v]);
            if (score[a].step != '0) begin
              d[v] = scaled_drive(cfg_gain[v], sine_q14(voice_phase[v]));
            end
            voice_phase[v] = voice_phase[v] + score[a].step;
            if (voice_elapsed[v] != TICKS_FULL) begin
              voice_elapsed[v] = voice_elapsed[v] + 1'b1;
            end
          end
        end
      end
      fr.drive_one = d[0];
      fr.drive_two = d[1];
      fr.busy_one  = on[0];
      fr.busy_two  = on[1];
      fr.finished  = !running;
      frames_due.push_back(fr);
    end
  endfunction

  // sender gaps: mostly none, some short, a few long
  function automatic int gap_after();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return '0;
    end else if (r < 20) begin
      return '1;
    end
    return $urandom();
  endfunction

  // short notes keep the voices moving, now and then a full range one
  function automatic logic [TICKS_W-1:0] rand_ticks();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(0, TICKS_FULL);
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic int unsigned pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 0;
    end else if (r < 30) begin
      return SLOT_COUNT - 1;
    end
    return $urandom_range(0, SLOT_COUNT - 1);
  endfunction

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 0;
    end else if (r < 20) begin
      return SLOT_COUNT;
    end else if (r < 35) begin
      return 1;
    end
    return $urandom_range(2, 8);
  endfunction

  function automatic int unsigned pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 0;
    end else if (r < 30) begin
      return 32768;
    end
    return $urandom_range(0, 32768);
  endfunction

  function automatic void send_note(logic [SLOT_W-1:0] slot, logic [STEP_W-1:0] step,
                                    logic [TICKS_W-1:0] ticks);
    cmds_waiting.push_back('{func: FUNC_LOAD, slot: slot, step: step, ticks: ticks,
                             drain: 1'b0});
  endfunction

  // non-load items carry random payload that the block must ignore
  function automatic void send_ctl(logic [FUNC_W-1:0] f, bit drain);
    cmds_waiting.push_back('{func: f, slot: SLOT_W'($urandom()), step: $urandom(),
                             ticks: TICKS_W'($urandom()), drain: drain});
  endfunction

  // apb write: setup cycle, access cycle, shadow copy follows the write edge
  task automatic write_reg(reg_e r, int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_BASE_ONE:   cfg_base[0] = SLOT_W'(val);
      REG_LENGTH_ONE: cfg_len[0]  = INDEX_W'(val);
      REG_BASE_TWO:   cfg_base[1] = SLOT_W'(val);
      REG_LENGTH_TWO: cfg_len[1]  = INDEX_W'(val);
      REG_GAIN_ONE:   cfg_gain[0] = GAIN_W'(val);
      REG_GAIN_TWO:   cfg_gain[1] = GAIN_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_voices(int unsigned b1, int unsigned l1, int unsigned b2,
                            int unsigned l2, int unsigned g1, int unsigned g2);
    write_reg(REG_BASE_ONE, b1);
    write_reg(REG_LENGTH_ONE, l1);
    write_reg(REG_BASE_TWO, b2);
    write_reg(REG_LENGTH_TWO, l2);
    write_reg(REG_GAIN_ONE, g1);
    write_reg(REG_GAIN_TWO, g2);
  endtask

  // wait for an idle block: nothing queued, nothing offered, no result due,
  // then a settling wait for loads and starts still inside
  task automatic quiesce();
    @(negedge clk_i);
    while (cmds_waiting.size() != 0 || in_valid || frames_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic compare_field(string what, logic signed [16:0] want, logic signed [16:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d got %0d", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  // sender: predicts on every accepted item, then offers the next one
  always @(posedge clk_i) begin : sender
    seq_cmd_t c;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        c.func  = in_func;
        c.slot  = in_slot;
        c.step  = in_step;
        c.ticks = in_ticks;
        c.drain = 1'b0;
        play_item(c);
      end
      // payload only moves once the current item is gone
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmds_waiting.size() != 0 &&
                     !(cmds_waiting[0].drain && frames_due.size() != 0)) begin
          c = cmds_waiting.pop_front();
          in_func  <= c.func;
          in_slot  <= c.slot;
          in_step  <= c.step;
          in_ticks <= c.ticks;
          in_valid <= 1'b1;
          gap_left <= gap_after();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each taken result against the oldest prediction
  always @(posedge clk_i) begin : receiver
    tone_frame_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $display("%0t unexpected result: expected none got drives %0d %0d",
                   $time, drive_one, drive_two);
          mismatch_total++;
        end else begin
          want = frames_due.pop_front();
          compare_field("drive_one", want.drive_one, drive_one);
          compare_field("drive_two", want.drive_two, drive_two);
          compare_field("voice_one_busy", want.busy_one, busy_one);
          compare_field("voice_two_busy", want.busy_two, busy_two);
          compare_field("finished", want.finished, finished);
        end
      end
      // stall bursts, mostly short, a few long, with open runs between
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_calm || run_left != 0) begin
        out_stall <= 1'b0;
        if (run_left != 0) begin
          run_left <= run_left - 1;
        end
      end else begin
        out_stall  <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
        run_left   <= $urandom_range(0, 12);
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    int k;
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: idle tick, ignored code, start with no notes
    send_ctl(FUNC_TICK, 1'b0);
    send_ctl(FUNC_UNUSED, 1'b0);
    send_ctl(FUNC_START, 1'b0);
    send_ctl(FUNC_TICK, 1'b0);

    // every slot written before any voice can read it
    for (k = 0; k < SLOT_COUNT; k++) begin
      if (k == 40) begin
        send_note(SLOT_W'(k), '1, TICKS_FULL);
      end else begin
        send_note(SLOT_W'(k), rand_step(), $urandom_range(0, 3));
      end
    end
    quiesce();

    // voice one wraps from the top slot at full gain, voice two silent gain
    // quarter turn steps hit the sine peaks, then rest, zero length note
    set_voices(62, 4, 0, 1, 32768, 0);
    send_note(6'd62, 32'h4000_0000, 24'd4);
    send_note(6'd63, 32'h0000_0000, 24'd1);
    send_note(6'd0, 32'hFFFF_FFFF, 24'd0);
    send_note(6'd1, 32'h8000_0000, 24'd2);
    send_ctl(FUNC_START, 1'b0);
    repeat (3) send_ctl(FUNC_TICK, 1'b0);
    // restart mid note, then play through to the end
    send_ctl(FUNC_START, 1'b0);
    repeat (10) send_ctl(FUNC_TICK, 1'b0);
    quiesce();

    // voice two disabled
    set_voices(5, 1, 0, 0, 8192, 8192);
    send_ctl(FUNC_START, 1'b0);
    repeat (3) send_ctl(FUNC_TICK, 1'b0);

    // random phases: start, then mostly ticks with loads and restarts mixed in
    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      tx_calm = (ph % 4 == 1);
      rx_calm = (ph % 4 == 2);
      if (ph == 0) begin
        set_voices(63, 64, 63, 64, 32768, 32768);
      end else if (ph == 1) begin
        set_voices(0, 1, 0, 0, 0, 0);
      end else begin
        set_voices(pick_base(), pick_len(), pick_base(), pick_len(), pick_gain(), pick_gain());
      end
      send_ctl(FUNC_START, 1'b0);
      n = 1;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        // sender holds until every result so far is back
        if ((ph == 3 || ph == 8) && n == PHASE_ITEMS / 2) begin
          send_ctl(FUNC_TICK, 1'b1);
        end else if (pick < 74) begin
          send_ctl(FUNC_TICK, 1'b0);
        end else if (pick < 88) begin
          send_note(SLOT_W'($urandom()), rand_step(), rand_ticks());
        end else if (pick < 93) begin
          send_ctl(FUNC_START, 1'b0);
        end else begin
          // ignored code, not counted
          send_ctl(FUNC_UNUSED, 1'b0);
          continue;
        end
        n++;
      end
    end

    quiesce();
    if (mismatch_total == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #RUN_LIMIT;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
